// ----- sv/l2vn_pkg.sv -----
// Package for the L2 vector normalizer: field widths, multiplier operand
// widths and the shared operand type. No dependencies.

package l2vn_pkg;

    localparam int MAX_LENGTH_DEF = 64;

    // Element and result fields.
    localparam int ELEM_W = 16;
    localparam int OUT_W  = 16;

    // Sum of squares in units of 2^-24.
    localparam int SUM_W = 38;

    // Result magnitude search range, 0 to one in Q1.14.
    localparam int MAG_W = 15;
    localparam logic [MAG_W-1:0] ONE_Q14 = 15'd16384;

    // Shared multiplier: A holds a square of up to 30 bits, B holds up to
    // 19 bits (a slice of the sum or a narrow factor).
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Square of an element magnitude (up to 2^30) and its scaling shift.
    localparam int SQ_W      = 31;
    localparam int ESQ_SHIFT = 30;

    // Width of the full product (t^2 * sum) used in the search compare.
    localparam int CMP_W = MUL_P_W + MUL_B_W;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_op_t;

endpackage

// ----- sv/l2vn_stream_if.sv -----
// Stream interfaces for the L2 vector normalizer input and result channels.
// Depends on l2vn_pkg for the field widths.

interface l2vn_in_if;
    import l2vn_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element;
    logic                     last;

    modport source (output valid, output element, output last, input ready);
    modport sink   (input valid, input element, input last, output ready);
endinterface

interface l2vn_out_if;
    import l2vn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] normalized;
    logic                    last_out;

    modport source (output valid, output normalized, output last_out, input ready);
    modport sink   (input valid, input normalized, input last_out, output ready);
endinterface

// ----- sv/l2vn_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on l2vn_pkg for the operand type and widths.

module l2vn_mul (
    input  logic                         clk,
    input  l2vn_pkg::mul_op_t            op,
    output logic [l2vn_pkg::MUL_P_W-1:0] product
);
    import l2vn_pkg::*;

    logic [MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
    end

    assign product = product_reg;

endmodule

// ----- sv/l2_vector_normalizer.sv -----
// Top level of the L2 vector normalizer: element buffer, sum of squares and
// the sequencer that drives the shared multiplier through a per-element search.
// Depends on l2vn_pkg, l2vn_stream_if and l2vn_mul.
//
//   Channel   Dir   Payload                       Transfer when
//   in_ch     in    element (s16 Q3.12), last     in_ch.valid && in_ch.ready
//   out_ch    out   normalized (s16 Q1.14),       out_ch.valid && out_ch.ready
//                   last_out
//
// Loading passes each element through two states: S_LOAD takes the transfer
// and squares the element, S_ACC adds the square to the running sum.
// After the last element each stored element goes through a buffer read,
// the element square, then a binary search over the result magnitude with
// S_SQ, S_P0, S_P1 and S_CMP per step (14 or 15 steps), all on the one multiplier.
// For an all-zero vector each element goes from S_ESQ straight to S_OUT.
// Reset clears the sum, the count and the sequencer; the buffer needs no clear.
// A stalled result is held in the output register while the next one is worked out.

module l2_vector_normalizer #(
    parameter int MAX_LENGTH = l2vn_pkg::MAX_LENGTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    l2vn_in_if.sink    in_ch,
    l2vn_out_if.source out_ch
);
    import l2vn_pkg::*;

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    // Sequencer states.
    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_ACC  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_ESQ  = 4'd3;
    localparam logic [3:0] S_INIT = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_P0   = 4'd6;
    localparam logic [3:0] S_P1   = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               stored_reg, stored_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;

    logic [MAG_W-1:0]   lo_reg, lo_next;
    logic [MAG_W-1:0]   hi_reg, hi_next;
    logic [MAG_W-1:0]   mid_reg, mid_next;
    logic [SQ_W-1:0]    esq_reg, esq_next;
    logic [MUL_A_W-1:0] t2_reg, t2_next;
    logic [MUL_P_W-1:0] p0_reg, p0_next;
    logic [ELEM_W-1:0]  res_reg, res_next;
    logic [OUT_W-1:0]   out_norm_reg, out_norm_next;
    logic               out_last_reg, out_last_next;

    logic [ELEM_W-1:0]  element_store_reg [MAX_LENGTH];
    logic [ELEM_W-1:0]  rd_data_reg;

    mul_op_t            mul_op;
    logic [MUL_P_W-1:0] product;

    logic               in_fire;
    logic               has_room;
    logic [ELEM_W-1:0]  in_mag;
    logic [ELEM_W-1:0]  rd_mag;
    logic [MAG_W:0]     mid_sum;
    logic [MAG_W-1:0]   mid_calc;
    logic [MAG_W:0]     t_wide;
    logic [MAG_W-1:0]   t_calc;
    logic [CMP_W-1:0]   prod_full;
    logic [CMP_W-1:0]   esq_scaled;
    logic               reaches;
    logic               can_load;
    logic               is_final;

    l2vn_mul u_mul (
        .clk     (clk),
        .op      (mul_op),
        .product (product)
    );

    assign in_ch.ready = (state_reg == S_LOAD);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign has_room    = (count_reg < CNT_W'(MAX_LENGTH));

    assign in_mag = in_ch.element[ELEM_W-1] ? (ELEM_W'(0) - $unsigned(in_ch.element))
                                            : $unsigned(in_ch.element);
    assign rd_mag = rd_data_reg[ELEM_W-1] ? (ELEM_W'(0) - rd_data_reg) : rd_data_reg;

    // Search midpoint and the odd factor t = 2*mid - 1 for the bound k - 1/2.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + (MAG_W + 1)'(1);
    assign mid_calc = mid_sum[MAG_W:1];
    assign t_wide   = {mid_calc, 1'b0} - (MAG_W + 1)'(1);
    assign t_calc   = t_wide[MAG_W-1:0];

    // In the compare state the multiplier holds t^2 times the upper sum slice.
    assign prod_full  = {product, {MUL_B_W{1'b0}}} + CMP_W'(p0_reg);
    assign esq_scaled = CMP_W'({esq_reg, {ESQ_SHIFT{1'b0}}});
    assign reaches    = (esq_scaled >= prod_full);

    assign can_load = !out_valid_reg || out_ch.ready;
    assign is_final = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_op.a = MUL_A_W'(in_mag);
        mul_op.b = MUL_B_W'(in_mag);
        case (state_reg)
            S_ESQ:
            begin
                mul_op.a = MUL_A_W'(rd_mag);
                mul_op.b = MUL_B_W'(rd_mag);
            end
            S_SQ:
            begin
                mul_op.a = MUL_A_W'(t_calc);
                mul_op.b = MUL_B_W'(t_calc);
            end
            S_P0:
            begin
                mul_op.a = product[MUL_A_W-1:0];
                mul_op.b = sum_reg[MUL_B_W-1:0];
            end
            S_P1:
            begin
                mul_op.a = t2_reg;
                mul_op.b = MUL_B_W'(sum_reg[SUM_W-1:MUL_B_W]);
            end
            default:
            begin
                mul_op.a = MUL_A_W'(in_mag);
                mul_op.b = MUL_B_W'(in_mag);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        stored_next    = stored_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        esq_next       = esq_reg;
        t2_next        = t2_reg;
        p0_next        = p0_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_norm_next  = out_norm_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    // Elements past the buffer depth are dropped, but their
                    // last mark still ends the vector.
                    stored_next = has_room;
                    last_next   = in_ch.last;
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (stored_reg)
                begin
                    sum_next = sum_reg + SUM_W'(product);
                end
                idx_next   = '0;
                state_next = last_reg ? S_RD : S_LOAD;
            end
            S_RD:
            begin
                state_next = S_ESQ;
            end
            S_ESQ:
            begin
                if (sum_reg == '0)
                begin
                    // All-zero vector: elements pass through unchanged.
                    res_next   = rd_data_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                esq_next   = product[SQ_W-1:0];
                lo_next    = '0;
                hi_next    = ONE_Q14;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (lo_reg == hi_reg)
                begin
                    res_next = rd_data_reg[ELEM_W-1] ? (ELEM_W'(0) - ELEM_W'(lo_reg))
                                                     : ELEM_W'(lo_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = S_P0;
                end
            end
            S_P0:
            begin
                t2_next    = product[MUL_A_W-1:0];
                state_next = S_P1;
            end
            S_P1:
            begin
                p0_next    = product;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (reaches)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg - MAG_W'(1);
                end
                state_next = S_SQ;
            end
            S_OUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_norm_next  = res_reg;
                    out_last_next  = is_final;
                    if (is_final)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            stored_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            stored_reg    <= stored_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        esq_reg      <= esq_next;
        t2_reg       <= t2_next;
        p0_reg       <= p0_next;
        res_reg      <= res_next;
        out_norm_reg <= out_norm_next;
        out_last_reg <= out_last_next;
    end

    // Element buffer: one write port for loading, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_fire && has_room)
        begin
            element_store_reg[count_reg[IDX_W-1:0]] <= $unsigned(in_ch.element);
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= element_store_reg[idx_reg];
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.normalized = $signed(out_norm_reg);
    assign out_ch.last_out   = out_last_reg;

endmodule
